// ===== design/sadt_pkg.sv =====
package sadt_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int MAX_OUT      = 32;
  localparam int CMD_W        = 3;
  localparam int SLOT_W       = 5;
  localparam int DATA_W       = 64;
  localparam int STATUS_W     = 2;
  localparam int OUT_CNT_W    = $clog2(MAX_OUT + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_FLUSH  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDW,
    ST_SCAN,
    ST_FRD,
    ST_FEND
  } state_t;

endpackage

// ===== design/slot_allocator_dirty_tracking.sv =====
// Slot table of CAPACITY 64-bit entries with a free list threaded through
// freed slots and one dirty mark per slot. Requests: add, remove, update, get
// and flush; unknown commands are dropped without a result. Payloads and free
// list links live in two single-port-read synchronous memories; free and
// dirty marks are flip-flops cleared by reset. Remove, update, bad-slot and
// fresh-slot or full add requests answer from the execute state; add from
// the free list and get first wait for the synchronous memory read. A flush
// walks the dirty marks one slot per cycle, pausing on each dirty slot for
// its payload read and while the output is held; it emits slots in ascending
// order with out_last on the final one, and emits nothing when nothing is
// dirty. At most 32 slots leave per flush; the rest stay dirty. A result
// waiting in the output register does not block acceptance of a request.
module slot_allocator_dirty_tracking #(
  parameter int CAPACITY = sadt_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sadt_pkg::CMD_W-1:0]    in_cmd,
  input  logic [sadt_pkg::SLOT_W-1:0]   in_slot,
  input  logic [sadt_pkg::DATA_W-1:0]   in_quad_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sadt_pkg::SLOT_W-1:0]   out_slot,
  output logic [sadt_pkg::DATA_W-1:0]   out_data,
  output logic [sadt_pkg::STATUS_W-1:0] out_status,
  output logic                          out_last
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > sadt_pkg::SLOT_W) ? CNTW : sadt_pkg::SLOT_W;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);
  localparam logic [CNTW-1:0] CAP_CNT  = CNTW'(CAPACITY);
  localparam logic [sadt_pkg::OUT_CNT_W-1:0] MAX_CNT =
    sadt_pkg::OUT_CNT_W'(sadt_pkg::MAX_OUT);

  sadt_pkg::state_t state_r, state_nxt;

  logic [sadt_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [sadt_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [sadt_pkg::DATA_W-1:0] data_r, data_nxt;
  logic [CNTW-1:0]             fh_r, fh_nxt;
  logic [CNTW-1:0]             hw_r, hw_nxt;
  logic [CAPACITY-1:0]         free_r, free_nxt;
  logic [CAPACITY-1:0]         dirty_r, dirty_nxt;
  logic [IDXW-1:0]             idx_r, idx_nxt;
  logic [sadt_pkg::OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [IDXW-1:0]             pend_slot_r, pend_slot_nxt;
  logic [sadt_pkg::DATA_W-1:0] pend_data_r, pend_data_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [sadt_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [sadt_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [sadt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [sadt_pkg::DATA_W-1:0] pay_mem [CAPACITY];
  logic [IDXW-1:0]             link_mem [CAPACITY];
  logic [sadt_pkg::DATA_W-1:0] pay_rdata_r;
  logic [IDXW-1:0]             link_rdata_r;

  logic                        pay_we, link_we, rd_en;
  logic [IDXW-1:0]             pay_waddr, link_waddr, link_wdata, rd_addr;

  logic out_free;
  logic slot_ok;
  logic [IDXW-1:0] slot_idx, fh_idx, hw_idx;

  assign in_ready   = (state_r == sadt_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  assign out_free = !out_valid_r || out_ready;
  assign slot_idx = IDXW'(slot_r);
  assign fh_idx   = IDXW'(fh_r);
  assign hw_idx   = IDXW'(hw_r);
  assign slot_ok  = (CMPW'(slot_r) < CMPW'(hw_r)) && !free_r[slot_idx];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    data_nxt       = data_r;
    fh_nxt         = fh_r;
    hw_nxt         = hw_r;
    free_nxt       = free_r;
    dirty_nxt      = dirty_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    pend_data_nxt  = pend_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_slot_nxt   = out_slot_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    pay_we         = 1'b0;
    pay_waddr      = slot_idx;
    link_we        = 1'b0;
    link_waddr     = slot_idx;
    link_wdata     = slot_idx;
    rd_en          = 1'b0;
    rd_addr        = slot_idx;

    unique case (state_r)
      sadt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          slot_nxt  = in_slot;
          data_nxt  = in_quad_data;
          state_nxt = sadt_pkg::ST_EXEC;
        end
      end

      sadt_pkg::ST_EXEC: begin
        case (cmd_r) inside
          sadt_pkg::CMD_ADD: begin
            if (fh_r != hw_r) begin
              rd_en     = 1'b1;
              rd_addr   = fh_idx;
              state_nxt = sadt_pkg::ST_RDW;
            end else if (out_free) begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_data_nxt  = '0;
              if (hw_r == CAP_CNT) begin
                out_slot_nxt   = '0;
                out_status_nxt = sadt_pkg::STATUS_FULL;
              end else begin
                pay_we            = 1'b1;
                pay_waddr         = hw_idx;
                dirty_nxt[hw_idx] = 1'b1;
                hw_nxt            = CNTW'(hw_r + 1'b1);
                fh_nxt            = CNTW'(hw_r + 1'b1);
                out_slot_nxt      = sadt_pkg::SLOT_W'(hw_r);
                out_status_nxt    = sadt_pkg::STATUS_OK;
              end
              state_nxt = sadt_pkg::ST_IDLE;
            end
          end

          sadt_pkg::CMD_REMOVE, sadt_pkg::CMD_UPDATE: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_slot_nxt  = slot_r;
              out_data_nxt  = '0;
              if (!slot_ok) begin
                out_status_nxt = sadt_pkg::STATUS_BAD_SLOT;
              end else begin
                out_status_nxt = sadt_pkg::STATUS_OK;
                if (cmd_r == sadt_pkg::CMD_REMOVE) begin
                  link_we             = 1'b1;
                  link_wdata          = (fh_r == hw_r) ? slot_idx : fh_idx;
                  free_nxt[slot_idx]  = 1'b1;
                  dirty_nxt[slot_idx] = 1'b0;
                  fh_nxt              = CNTW'(slot_r);
                end else begin
                  pay_we              = 1'b1;
                  dirty_nxt[slot_idx] = 1'b1;
                end
              end
              state_nxt = sadt_pkg::ST_IDLE;
            end
          end

          sadt_pkg::CMD_GET: begin
            if (slot_ok) begin
              rd_en     = 1'b1;
              state_nxt = sadt_pkg::ST_RDW;
            end else if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_last_nxt   = 1'b1;
              out_slot_nxt   = slot_r;
              out_data_nxt   = '0;
              out_status_nxt = sadt_pkg::STATUS_BAD_SLOT;
              state_nxt      = sadt_pkg::ST_IDLE;
            end
          end

          sadt_pkg::CMD_FLUSH: begin
            idx_nxt    = '0;
            cnt_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = sadt_pkg::ST_SCAN;
          end

          default: begin
            state_nxt = sadt_pkg::ST_IDLE;
          end
        endcase
      end

      sadt_pkg::ST_RDW: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_status_nxt = sadt_pkg::STATUS_OK;
          if (cmd_r == sadt_pkg::CMD_ADD) begin
            pay_we            = 1'b1;
            pay_waddr         = fh_idx;
            dirty_nxt[fh_idx] = 1'b1;
            free_nxt[fh_idx]  = 1'b0;
            fh_nxt            = (link_rdata_r == fh_idx) ? hw_r : CNTW'(link_rdata_r);
            out_slot_nxt      = sadt_pkg::SLOT_W'(fh_r);
            out_data_nxt      = '0;
          end else begin
            out_slot_nxt = slot_r;
            out_data_nxt = pay_rdata_r;
          end
          state_nxt = sadt_pkg::ST_IDLE;
        end
      end

      sadt_pkg::ST_SCAN: begin
        if (cnt_r == MAX_CNT) begin
          state_nxt = sadt_pkg::ST_FEND;
        end else if (dirty_r[idx_r]) begin
          rd_en            = 1'b1;
          rd_addr          = idx_r;
          dirty_nxt[idx_r] = 1'b0;
          state_nxt        = sadt_pkg::ST_FRD;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = sadt_pkg::ST_FEND;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      sadt_pkg::ST_FRD: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_last_nxt   = 1'b0;
            out_slot_nxt   = sadt_pkg::SLOT_W'(pend_slot_r);
            out_data_nxt   = pend_data_r;
            out_status_nxt = sadt_pkg::STATUS_OK;
          end
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = idx_r;
          pend_data_nxt = pay_rdata_r;
          cnt_nxt       = cnt_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = sadt_pkg::ST_FEND;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = sadt_pkg::ST_SCAN;
          end
        end
      end

      sadt_pkg::ST_FEND: begin
        if (!pend_v_r) begin
          state_nxt = sadt_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_slot_nxt   = sadt_pkg::SLOT_W'(pend_slot_r);
          out_data_nxt   = pend_data_r;
          out_status_nxt = sadt_pkg::STATUS_OK;
          pend_v_nxt     = 1'b0;
          state_nxt      = sadt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sadt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sadt_pkg::ST_IDLE;
      fh_r        <= '0;
      hw_r        <= '0;
      free_r      <= '0;
      dirty_r     <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fh_r        <= fh_nxt;
      hw_r        <= hw_nxt;
      free_r      <= free_nxt;
      dirty_r     <= dirty_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    data_r       <= data_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_data_r  <= pend_data_nxt;
    out_slot_r   <= out_slot_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= data_r;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      pay_rdata_r  <= pay_mem[rd_addr];
      link_rdata_r <= link_mem[rd_addr];
    end
  end

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= CAP_CNT)
    else $error("high-water mark beyond capacity");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fh_r != hw_r) |-> (fh_r < hw_r && free_r[fh_idx]))
    else $error("free-list head not a freed slot");

  a_free_not_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r & dirty_r) == '0)
    else $error("slot on free list is dirty");

  a_pend_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == sadt_pkg::ST_SCAN || state_r == sadt_pkg::ST_FRD ||
                  state_r == sadt_pkg::ST_FEND))
    else $error("flush holding slot outside flush");

  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("flush emitted too many slots");

endmodule
